// ----- rtl/core/lut_sum_color_convert_macros.svh -----
// ----------------------------------------------------------------------------
// lut_sum_color_convert_macros.svh
// Assertion macros shared by the converter RTL. Each expects clk and rst in
// the enclosing module.
// ----------------------------------------------------------------------------
`ifndef LUT_SUM_COLOR_CONVERT_MACROS_SVH
`define LUT_SUM_COLOR_CONVERT_MACROS_SVH

// same-cycle implication
`define LSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lsc_pkg
// Types, constants and helpers for the table-sum color converter.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int TABLE_ENTRIES = 65536;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int NUM_TABLES    = 3;
  localparam int NUM_LANES     = 4;
  localparam int LANE_W        = 16;
  localparam int ENTRY_W       = NUM_LANES * LANE_W;
  localparam int CODE_W        = 16;
  localparam int PADDR_W       = 3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    TBL_RED   = 2'd0,
    TBL_GREEN = 2'd1,
    TBL_BLUE  = 2'd2
  } table_sel_t;

  typedef enum logic [2:0] {
    FMT_BGRA16      = 3'd0,
    FMT_RGBA16      = 3'd1,
    FMT_BGR16       = 3'd2,
    FMT_RGB16       = 3'd3,
    FMT_GRAYA16     = 3'd4,
    FMT_GRAY16      = 3'd5,
    FMT_A2B10G10R10 = 3'd6
  } pixel_fmt_t;

  typedef enum logic {
    REG_PIXEL_FORMAT = 1'b0
  } reg_index_t;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         table_select;
    logic [15:0]        table_index;
    logic signed [15:0] entry_lane0;
    logic signed [15:0] entry_lane1;
    logic signed [15:0] entry_lane2;
    logic signed [15:0] entry_lane3;
    logic [63:0]        pixel_word;
    logic               end_of_row;
    logic               end_of_frame;
  } req_t;

  typedef struct packed {
    logic signed [15:0] out_lane0;
    logic signed [15:0] out_lane1;
    logic signed [15:0] out_lane2;
    logic signed [15:0] out_lane3;
    logic               row_done;
    logic               frame_done;
  } rsp_t;

  // control riding alongside the table read
  typedef struct packed {
    logic                  valid;
    logic                  rgb_order;
    logic [NUM_TABLES-1:0] zero;
    logic                  row_done;
    logic                  frame_done;
  } s1_ctrl_t;

  function automatic logic signed [LANE_W-1:0] sat_add(
    input logic signed [LANE_W-1:0] a,
    input logic signed [LANE_W-1:0] b
  );
    logic signed [LANE_W:0]   s;
    logic signed [LANE_W-1:0] r;
    s = {a[LANE_W-1], a} + {b[LANE_W-1], b};
    if (s[LANE_W] != s[LANE_W-1]) begin
      r = s[LANE_W] ? {1'b1, {(LANE_W-1){1'b0}}} : {1'b0, {(LANE_W-1){1'b1}}};
    end else begin
      r = s[LANE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/lsc_ram.sv -----
// ----------------------------------------------------------------------------
// lsc_ram
// Generic single-port RAM: a write, a registered read, or both, per cycle.
// ----------------------------------------------------------------------------
module lsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/core/lsc_fetch.sv -----
// ----------------------------------------------------------------------------
// lsc_fetch
// Unpacks the pixel into channel codes and drives the three channel tables:
// entry writes and the per-pixel table reads, plus the read-stage control.
// ----------------------------------------------------------------------------
`include "lut_sum_color_convert_macros.svh"

module lsc_fetch (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             accept,
  input  logic                                             advance,
  input  lsc_pkg::req_t                                    req,
  input  lsc_pkg::pixel_fmt_t                              pixel_format,
  output lsc_pkg::s1_ctrl_t                                s1,
  output logic [lsc_pkg::NUM_TABLES-1:0][lsc_pkg::ENTRY_W-1:0] q
);

  logic [lsc_pkg::NUM_TABLES-1:0][lsc_pkg::CODE_W-1:0] code;
  logic [lsc_pkg::NUM_TABLES-1:0][lsc_pkg::TBL_AW-1:0] addr;
  logic [lsc_pkg::NUM_TABLES-1:0]                      we;
  logic [lsc_pkg::NUM_TABLES-1:0]                      re;
  logic [lsc_pkg::NUM_TABLES-1:0]                      zero;
  logic [lsc_pkg::ENTRY_W-1:0]                         wdata;
  logic                                                is_pixel;
  logic                                                idx_ok;
  lsc_pkg::s1_ctrl_t                                   s1_next;

  assign is_pixel = (req.opcode == lsc_pkg::OP_PIXEL);
  assign idx_ok   = ({1'b0, req.table_index} < (lsc_pkg::CODE_W + 1)'(lsc_pkg::TABLE_ENTRIES));
  assign wdata    = {req.entry_lane3, req.entry_lane2, req.entry_lane1, req.entry_lane0};

  always_comb begin
    code[lsc_pkg::TBL_GREEN] = req.pixel_word[31:16];
    case (pixel_format)
      lsc_pkg::FMT_BGRA16, lsc_pkg::FMT_BGR16: begin
        code[lsc_pkg::TBL_BLUE] = req.pixel_word[15:0];
        code[lsc_pkg::TBL_RED]  = req.pixel_word[47:32];
      end
      lsc_pkg::FMT_RGBA16, lsc_pkg::FMT_RGB16: begin
        code[lsc_pkg::TBL_RED]  = req.pixel_word[15:0];
        code[lsc_pkg::TBL_BLUE] = req.pixel_word[47:32];
      end
      lsc_pkg::FMT_A2B10G10R10: begin
        code[lsc_pkg::TBL_RED]   = {6'b0, req.pixel_word[9:0]};
        code[lsc_pkg::TBL_GREEN] = {6'b0, req.pixel_word[19:10]};
        code[lsc_pkg::TBL_BLUE]  = {6'b0, req.pixel_word[29:20]};
      end
      default: begin
        code[lsc_pkg::TBL_RED]   = req.pixel_word[15:0];
        code[lsc_pkg::TBL_GREEN] = req.pixel_word[15:0];
        code[lsc_pkg::TBL_BLUE]  = req.pixel_word[15:0];
      end
    endcase
  end

  always_comb begin
    for (int t = 0; t < lsc_pkg::NUM_TABLES; t++) begin
      we[t]   = accept && !is_pixel && idx_ok && (req.table_select == 2'(t));
      re[t]   = accept && is_pixel;
      zero[t] = ({1'b0, code[t]} >= (lsc_pkg::CODE_W + 1)'(lsc_pkg::TABLE_ENTRIES));
      addr[t] = is_pixel ? code[t][lsc_pkg::TBL_AW-1:0]
                         : req.table_index[lsc_pkg::TBL_AW-1:0];
    end
  end

  for (genvar t = 0; t < lsc_pkg::NUM_TABLES; t++) begin : g_tbl
    lsc_ram #(
      .WIDTH(lsc_pkg::ENTRY_W),
      .DEPTH(lsc_pkg::TABLE_ENTRIES)
    ) u_ram (
      .clk  (clk),
      .we   (we[t]),
      .re   (re[t]),
      .addr (addr[t]),
      .wdata(wdata),
      .rdata(q[t])
    );
  end

  always_comb begin
    s1_next = s1;
    if (accept) begin
      s1_next.valid = is_pixel;
      if (is_pixel) begin
        s1_next.rgb_order  = (pixel_format == lsc_pkg::FMT_A2B10G10R10);
        s1_next.zero       = zero;
        s1_next.row_done   = req.end_of_row;
        s1_next.frame_done = req.end_of_frame;
      end
    end else if (advance) begin
      s1_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= s1_next.valid;
    end
    s1.rgb_order  <= s1_next.rgb_order;
    s1.zero       <= s1_next.zero;
    s1.row_done   <= s1_next.row_done;
    s1.frame_done <= s1_next.frame_done;
  end

  `LSC_ASSERT_NOW(a_one_table_write, 1'b1, $onehot0(we), "write hit more than one table")
  `LSC_ASSERT_NEXT(a_pixel_in_read, accept && is_pixel, s1.valid, "pixel read lost")
  `LSC_ASSERT_NEXT(a_write_no_read, accept && !is_pixel && !s1.valid, !s1.valid,
    "write beat produced a read")

endmodule

// ----- rtl/core/lsc_accum.sv -----
// ----------------------------------------------------------------------------
// lsc_accum
// Saturating lane sums of the three table entries and the output register.
// ----------------------------------------------------------------------------
module lsc_accum (
  input  logic                                             clk,
  input  logic                                             rst,
  input  lsc_pkg::s1_ctrl_t                                s1,
  input  logic [lsc_pkg::NUM_TABLES-1:0][lsc_pkg::ENTRY_W-1:0] q,
  input  logic                                             rsp_stall,
  output logic                                             advance,
  output logic                                             rsp_valid,
  output lsc_pkg::rsp_t                                    rsp
);

  logic signed [lsc_pkg::NUM_LANES-1:0][lsc_pkg::LANE_W-1:0] lane_sum;
  logic [lsc_pkg::NUM_TABLES-1:0][lsc_pkg::ENTRY_W-1:0]     ent;
  logic signed [lsc_pkg::LANE_W-1:0]                        r_l;
  logic signed [lsc_pkg::LANE_W-1:0]                        g_l;
  logic signed [lsc_pkg::LANE_W-1:0]                        b_l;
  lsc_pkg::rsp_t                                            rsp_next;

  assign advance = s1.valid && (!rsp_valid || !rsp_stall);

  always_comb begin
    for (int t = 0; t < lsc_pkg::NUM_TABLES; t++) begin
      ent[t] = s1.zero[t] ? '0 : q[t];
    end
    for (int k = 0; k < lsc_pkg::NUM_LANES; k++) begin
      r_l = ent[lsc_pkg::TBL_RED][k*lsc_pkg::LANE_W +: lsc_pkg::LANE_W];
      g_l = ent[lsc_pkg::TBL_GREEN][k*lsc_pkg::LANE_W +: lsc_pkg::LANE_W];
      b_l = ent[lsc_pkg::TBL_BLUE][k*lsc_pkg::LANE_W +: lsc_pkg::LANE_W];
      if (s1.rgb_order) begin
        lane_sum[k] = lsc_pkg::sat_add(lsc_pkg::sat_add(r_l, g_l), b_l);
      end else begin
        lane_sum[k] = lsc_pkg::sat_add(lsc_pkg::sat_add(b_l, g_l), r_l);
      end
    end
    rsp_next.out_lane0  = lane_sum[0];
    rsp_next.out_lane1  = lane_sum[1];
    rsp_next.out_lane2  = lane_sum[2];
    rsp_next.out_lane3  = lane_sum[3];
    rsp_next.row_done   = s1.row_done;
    rsp_next.frame_done = s1.frame_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- rtl/core/lut_sum_color_convert.sv -----
// ----------------------------------------------------------------------------
// lut_sum_color_convert
// Table-sum color converter: three channel tables, saturating lane sums.
//
// Request channel (req_valid/req_stall/req): a write beat (opcode 0) loads
// one 64-bit entry of the red, green or blue table; a pixel beat (opcode 1)
// is unpacked per pixel_format, each channel code reads its table, and the
// four lanes of the three entries are summed with 16-bit saturation.
// Response channel (rsp_valid/rsp_stall/rsp): one beat per pixel, in order,
// carrying the row and frame marks. Write beats give no response.
// Throughput: one beat per cycle unless stalled, set by the single-port RAMs.
// A pixel goes through the table read stage, then the output register.
// A write is visible to a pixel accepted in the very next cycle.
// When rsp_stall holds, one pixel waits in the output register and one in
// the table read stage; req_stall then rises until the output drains.
// Reset clears the pipeline valids and sets pixel_format to BGRA16. Table
// contents are not cleared; entries must be written before use.
// APB: pixel_format at byte address 0, pready always high.
// ----------------------------------------------------------------------------
`include "lut_sum_color_convert_macros.svh"

module lut_sum_color_convert (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  lsc_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output lsc_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  lsc_pkg::pixel_fmt_t                                     pixel_format;
  lsc_pkg::s1_ctrl_t                                       s1;
  logic [lsc_pkg::NUM_TABLES-1:0][lsc_pkg::ENTRY_W-1:0]   q;
  logic                                                    advance;
  logic                                                    accept;
  logic                                                    reg_hit;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[2] == lsc_pkg::REG_PIXEL_FORMAT);
  assign prdata    = reg_hit ? {29'b0, pixel_format} : '0;
  assign req_stall = s1.valid && !advance;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= lsc_pkg::FMT_BGRA16;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      pixel_format <= lsc_pkg::pixel_fmt_t'(pwdata[2:0]);
    end
  end

  lsc_fetch u_fetch (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .advance     (advance),
    .req         (req),
    .pixel_format(pixel_format),
    .s1          (s1),
    .q           (q)
  );

  lsc_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .q        (q),
    .rsp_stall(rsp_stall),
    .advance  (advance),
    .rsp_valid(rsp_valid),
    .rsp      (rsp)
  );

  `LSC_ASSERT_NEXT(a_read_held, s1.valid && rsp_valid && rsp_stall, s1.valid,
    "pixel dropped from read stage under stall")
  `LSC_ASSERT_NOW(a_stall_cause, req_stall, s1.valid && rsp_valid,
    "request stalled with room in the pipe")

endmodule
